// File: sv/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ucd_pkg;

	localparam int MaxNodesDefault = 64;
	localparam int NodeW           = 6;
	localparam int CountW          = 7;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_QUERY  = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [CountW-1:0] NodeCountReset = 7'd64;
	localparam logic [CountW-1:0] NoParent       = 7'd127;

	typedef struct packed {
		logic add_edge;
		logic edge_b;
		logic edge_wr;
		logic clear_all;
		logic init_walk;
		logic root_step;
		logic push_root;
		logic load_row;
		logic scan;
		logic push_nb;
	} ucd_cmd_t;

	typedef struct packed {
		logic root_done;
		logic root_visited;
		logic stack_empty;
		logic push_req;
		logic found;
		logic edge_bad;
	} ucd_sts_t;

endpackage

// File: sv/ucd_ctrl.sv
// ----------------------------------------------------------------------------
// ucd_ctrl
// sequencer for edge loads, clears and the depth-first cycle query
// ----------------------------------------------------------------------------
module ucd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        mode,
	input  ucd_pkg::ucd_sts_t sts,
	output ucd_pkg::ucd_cmd_t cmd,
	output logic              busy,
	output logic              done,
	output logic              status,
	output logic              cycle_found
);
	import ucd_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ROOT = 4'd1;
	localparam logic [3:0] S_LOAD = 4'd2;
	localparam logic [3:0] S_WAIT = 4'd3;
	localparam logic [3:0] S_SCAN = 4'd4;
	localparam logic [3:0] S_PUSH = 4'd5;
	localparam logic [3:0] S_ARD  = 4'd6;
	localparam logic [3:0] S_AWR  = 4'd7;
	localparam logic [3:0] S_BRD  = 4'd8;
	localparam logic [3:0] S_BWR  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       done_q;
	logic       status_q;
	logic       found_q;
	logic       accept;

	assign accept = start && state_q == S_IDLE;
	assign busy   = state_q != S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.clear_all = mode == MODE_CLEAR;
					if (mode == MODE_QUERY) begin
						cmd.init_walk = 1'b1;
						state_d       = S_ROOT;
					end else if (mode == MODE_ADD && !sts.edge_bad) begin
						cmd.add_edge = 1'b1;
						state_d      = S_ARD;
					end
				end
			end
			S_ARD: state_d = S_AWR;
			S_AWR: begin
				cmd.edge_wr = 1'b1;
				state_d     = S_BRD;
			end
			S_BRD: begin
				cmd.edge_b = 1'b1;
				state_d    = S_BWR;
			end
			S_BWR: begin
				cmd.edge_b  = 1'b1;
				cmd.edge_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_ROOT: begin
				if (sts.root_done) begin
					state_d = S_IDLE;
				end else if (sts.root_visited) begin
					cmd.root_step = 1'b1;
				end else begin
					cmd.push_root = 1'b1;
					state_d       = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.stack_empty) begin
					cmd.root_step = 1'b1;
					state_d       = S_ROOT;
				end else begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				cmd.load_row = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found) state_d = S_IDLE;
				else if (sts.push_req) state_d = S_PUSH;
				else state_d = S_LOAD;
			end
			S_PUSH: begin
				cmd.push_nb = 1'b1;
				state_d     = S_LOAD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= (accept && mode != MODE_QUERY && !cmd.add_edge) ||
				state_q == S_BWR || (state_q == S_ROOT && sts.root_done) ||
				(state_q == S_SCAN && sts.found);
			status_q <= accept && mode == MODE_ADD && !cmd.add_edge;
			found_q  <= state_q == S_SCAN && sts.found;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign cycle_found = found_q;

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		status_q |-> done_q && !found_q) else $error("status without done");
	a_found_q: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> done_q) else $error("found without done");
	a_busy_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept) else $error("accept while busy");

endmodule

// File: sv/ucd_ram.sv
// ----------------------------------------------------------------------------
// ucd_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module ucd_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

// File: sv/ucd_dp.sv
// ----------------------------------------------------------------------------
// ucd_dp
// adjacency matrix, visited marks, walk stack and row scanner
// ----------------------------------------------------------------------------
module ucd_dp #(
	parameter int MaxNodes = ucd_pkg::MaxNodesDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ucd_pkg::ucd_cmd_t           cmd,
	input  logic [ucd_pkg::NodeW-1:0]   node_a,
	input  logic [ucd_pkg::NodeW-1:0]   node_b,
	input  logic [ucd_pkg::CountW-1:0]  node_count,
	output ucd_pkg::ucd_sts_t           sts
);
	import ucd_pkg::*;

	localparam int IdxW   = $clog2(MaxNodes);
	localparam int DepW   = $clog2(MaxNodes + 1);
	localparam int FrameW = NodeW + 2 * CountW;
	localparam logic [CountW-1:0] MaxC = CountW'(MaxNodes);

	logic [MaxNodes-1:0] row_vld_q;
	logic [MaxNodes-1:0] visited_q;
	logic [CountW-1:0]   n_eff;
	logic [CountW-1:0]   root_q;
	logic [DepW-1:0]     depth_q;
	logic [NodeW-1:0]    a_q;
	logic [NodeW-1:0]    b_q;
	logic [IdxW-1:0]     nb_q;
	logic [MaxNodes-1:0] row;
	logic [MaxNodes-1:0] cand;
	logic [MaxNodes-1:0] active;
	logic [MaxNodes-1:0] unscanned;
	logic                any;
	logic [IdxW-1:0]     j;
	logic [IdxW-1:0]     top;
	logic                adj_we;
	logic [IdxW-1:0]     adj_addr;
	logic [MaxNodes-1:0] adj_wdata;
	logic [MaxNodes-1:0] adj_rdata;
	logic [IdxW-1:0]     edge_row;
	logic [IdxW-1:0]     edge_col;
	logic                st_we;
	logic [IdxW-1:0]     st_addr;
	logic [FrameW-1:0]   st_wdata;
	logic [FrameW-1:0]   st_rdata;
	logic [NodeW-1:0]    cur_node;
	logic [CountW-1:0]   cur_par;
	logic [CountW-1:0]   cur_scan;
	logic                push_req;
	logic                found_c;

	assign n_eff    = node_count > MaxC ? MaxC : node_count;
	assign top      = IdxW'(depth_q - DepW'(1));
	assign cur_node = st_rdata[FrameW-1:2*CountW];
	assign cur_par  = st_rdata[2*CountW-1:CountW];
	assign cur_scan = st_rdata[CountW-1:0];

	always_comb begin
		for (int i = 0; i < MaxNodes; i++) active[i] = CountW'(i) < n_eff;
	end

	// frame scan position: row bits below it were already taken
	assign unscanned = {MaxNodes{1'b1}} << cur_scan;
	assign row       = row_vld_q[IdxW'(cur_node)] ? adj_rdata : '0;
	assign cand      = row & active & unscanned;

	always_comb begin
		any = 1'b0;
		j   = '0;
		for (int i = MaxNodes - 1; i >= 0; i--) begin
			if (cand[i]) begin
				any = 1'b1;
				j   = IdxW'(i);
			end
		end
	end

	assign push_req = any && !visited_q[j];
	assign found_c  = any && visited_q[j] && CountW'(j) != cur_par;

	// adjacency rows: read-modify-write per endpoint, row valid flags for clear
	assign edge_row  = cmd.edge_b ? IdxW'(b_q) : IdxW'(a_q);
	assign edge_col  = cmd.edge_b ? IdxW'(a_q) : IdxW'(b_q);
	assign adj_addr  = cmd.load_row ? IdxW'(cur_node) : edge_row;
	assign adj_we    = cmd.edge_wr;
	assign adj_wdata = (row_vld_q[edge_row] ? adj_rdata : '0) |
		({{(MaxNodes-1){1'b0}}, 1'b1} << edge_col);

	ucd_ram #(.Width(MaxNodes), .Depth(MaxNodes)) u_adj (
		.clk  (clk),
		.we   (adj_we),
		.addr (adj_addr),
		.wdata(adj_wdata),
		.rdata(adj_rdata)
	);

	always_comb begin
		st_we    = 1'b0;
		st_addr  = top;
		st_wdata = {cur_node, cur_par, CountW'(j) + CountW'(1)};
		if (cmd.push_root) begin
			st_we    = 1'b1;
			st_addr  = '0;
			st_wdata = {NodeW'(root_q), NoParent, CountW'(0)};
		end else if (cmd.push_nb) begin
			st_we    = depth_q < DepW'(MaxNodes);
			st_addr  = IdxW'(depth_q);
			st_wdata = {NodeW'(nb_q), CountW'(cur_node), CountW'(0)};
		end else if (cmd.scan) begin
			st_we = any;
		end
	end

	ucd_ram #(.Width(FrameW), .Depth(MaxNodes)) u_stack (
		.clk  (clk),
		.we   (st_we),
		.addr (st_addr),
		.wdata(st_wdata),
		.rdata(st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			visited_q <= '0;
			depth_q   <= '0;
			root_q    <= '0;
			a_q       <= '0;
			b_q       <= '0;
			nb_q      <= '0;
		end else begin
			if (cmd.clear_all) row_vld_q <= '0;
			if (cmd.edge_wr) row_vld_q[edge_row] <= 1'b1;
			if (cmd.add_edge) begin
				a_q <= node_a;
				b_q <= node_b;
			end
			if (cmd.init_walk) begin
				visited_q <= '0;
				depth_q   <= '0;
				root_q    <= '0;
			end
			if (cmd.root_step) root_q <= root_q + CountW'(1);
			if (cmd.push_root) begin
				visited_q[IdxW'(root_q)] <= 1'b1;
				depth_q <= DepW'(1);
			end
			if (cmd.scan) begin
				if (!any) depth_q <= depth_q - DepW'(1);
				if (push_req) nb_q <= j;
			end
			if (cmd.push_nb) begin
				visited_q[nb_q] <= 1'b1;
				if (depth_q < DepW'(MaxNodes)) depth_q <= depth_q + DepW'(1);
			end
		end
	end

	always_comb begin
		sts.root_done    = root_q >= n_eff;
		sts.root_visited = visited_q[IdxW'(root_q)];
		sts.stack_empty  = depth_q == '0;
		sts.push_req     = push_req;
		sts.found        = found_c;
		sts.edge_bad     = {1'b0, node_a} >= n_eff || {1'b0, node_b} >= n_eff;
	end

	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DepW'(MaxNodes)) else $error("stack overflow");
	a_push_vis: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_nb |=> visited_q[$past(nb_q)]) else $error("push not marked");
	a_root_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_root |-> depth_q == '0) else $error("root push on live stack");

endmodule

// File: sv/undirected_cycle_detect.sv
// ----------------------------------------------------------------------------
// undirected_cycle_detect
// adjacency matrix loader and depth-first cycle detector
// ----------------------------------------------------------------------------
// channel   signals                          handshake
// command   start, mode, node_a, node_b      start && !busy
// result    done, status, cycle_found        done, one cycle
// config    psel..pready (node_count @ 0)    psel && penable && pwrite && pready
//
// clear, unused mode and a rejected add: result the cycle after acceptance.
// an accepted add does two read-modify-writes of the row memory: busy through
// states ARD, AWR, BRD and BWR, result registered as BWR ends.
// a query steps through LOAD, WAIT and SCAN per row scan step, PUSH per push
// and ROOT per root, and stops at the first cycle found.
// reset empties the graph, node_count returns to 64; clear drops row valid flags.
// results cannot be stalled; done pulses one cycle.
module undirected_cycle_detect #(
	parameter int MaxNodes = ucd_pkg::MaxNodesDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 mode,
	input  logic [ucd_pkg::NodeW-1:0]  node_a,
	input  logic [ucd_pkg::NodeW-1:0]  node_b,
	output logic                       done,
	output logic                       status,
	output logic                       cycle_found,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [1:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ucd_pkg::*;

	logic [CountW-1:0] node_count_q;
	ucd_cmd_t          cmd;
	ucd_sts_t          sts;

	assign pready = 1'b1;
	assign prdata = paddr == 2'd0 ? {25'd0, node_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= NodeCountReset;
		else if (psel && penable && pwrite && paddr == 2'd0)
			node_count_q <= pwdata[CountW-1:0];
	end

	ucd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode), .sts(sts), .cmd(cmd),
		.busy(busy), .done(done), .status(status), .cycle_found(cycle_found)
	);

	ucd_dp #(.MaxNodes(MaxNodes)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .node_a(node_a), .node_b(node_b),
		.node_count(node_count_q), .sts(sts)
	);

endmodule

// File: tb/undirected_cycle_detect_tb.sv
// ----------------------------------------------------------------------------
// undirected_cycle_detect_tb
// drives edge loads, clears and cycle queries into the detector, predicts
// each result from a local copy of the adjacency matrix and node count, and
// compares every strobed result in order; node_count is rewritten between
// phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module undirected_cycle_detect_tb;
	import ucd_pkg::*;

	typedef struct packed {
		logic [1:0]       mode;
		logic [NodeW-1:0] a;
		logic [NodeW-1:0] b;
	} cmd_t;

	typedef struct packed {
		logic status;
		logic cyc;
	} res_t;

	localparam int WatchdogLimit = 40000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] mode = '0;
	logic [NodeW-1:0] node_a = '0;
	logic [NodeW-1:0] node_b = '0;
	logic done, status, cycle_found;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	undirected_cycle_detect dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.node_a(node_a), .node_b(node_b), .done(done), .status(status),
		.cycle_found(cycle_found), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	cmd_t pending_cmds[$];
	res_t expected_results[$];
	logic [63:0] adj[64];
	logic [CountW-1:0] count_model = NodeCountReset;
	int mismatches = 0;
	int gap_left = 0;
	bit idle_en = 1;
	int accepted_cmds = 0;
	int watchdog = 0;

	function automatic int active_n();
		return (count_model > 64) ? 64 : int'(count_model);
	endfunction

	function automatic logic detect_cycle();
		int n, sp, cur, j, root;
		logic [63:0] vis;
		int stk_node[64], stk_par[64], stk_scan[64];
		logic [63:0] row;
		logic found;
		n = active_n();
		vis = '0;
		sp = 0;
		found = 0;
		for (root = 0; root < n && !found; root++) begin
			if (vis[root]) continue;
			stk_node[0] = root; stk_par[0] = 127; stk_scan[0] = 0;
			sp = 1;
			vis[root] = 1;
			while (sp > 0 && !found) begin
				cur = stk_node[sp-1];
				row = (cur < n) ? adj[cur] : '0;
				j = stk_scan[sp-1];
				while (j < n && !row[j]) j++;
				if (j >= n) begin
					sp--;
					continue;
				end
				stk_scan[sp-1] = j + 1;
				if (!vis[j]) begin
					stk_node[sp] = j; stk_par[sp] = cur; stk_scan[sp] = 0;
					sp++;
					vis[j] = 1;
				end else if (j != stk_par[sp-1]) begin
					found = 1;
				end
			end
		end
		return found;
	endfunction

	function automatic res_t predict_result(cmd_t c);
		res_t r;
		int n;
		r = '0;
		n = active_n();
		case (c.mode)
			MODE_ADD: begin
				if (c.a >= n || c.b >= n) r.status = 1;
				else begin
					adj[c.a][c.b] = 1;
					adj[c.b][c.a] = 1;
				end
			end
			MODE_QUERY: r.cyc = detect_cycle();
			MODE_CLEAR: foreach (adj[i]) adj[i] = '0;
			default: ;
		endcase
		return r;
	endfunction

	logic start_taken;
	always @(posedge clk) begin
		start_taken <= start && !busy && arst_n;
		if (start && !busy && arst_n) begin
			expected_results = {expected_results, predict_result({mode, node_a, node_b})};
			accepted_cmds++;
		end
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n || psel) begin
			start <= 0;
		end else if (start && !start_taken) begin
		end else if (busy) begin
			start <= 0;
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			gap_left = $urandom_range(0, 6);
			start <= 0;
		end else if (pending_cmds.size() > 0) begin
			cmd_t c;
			c = pending_cmds.pop_front();
			mode <= c.mode;
			node_a <= c.a;
			node_b <= c.b;
			start <= 1;
		end else begin
			start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			res_t got, want;
			got = {status, cycle_found};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction: %b", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status exp %b got %b, cycle_found exp %b got %b",
							want.status, got.status, want.cyc, got.cyc);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || psel) watchdog <= 0;
		else watchdog <= watchdog + 1;
		if (watchdog > WatchdogLimit) begin
			$display("undirected_cycle_detect_tb failed");
			$finish;
		end
	end

	task automatic queue_cmd(logic [1:0] m, int a, int b);
		cmd_t c;
		c = '{m, NodeW'(a), NodeW'(b)};
		pending_cmds = {pending_cmds, c};
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_count(int v);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= '0; pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		count_model = CountW'(v);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic random_phase(int items, int n);
		int i, k, lim;
		lim = (n < 1) ? 1 : n;
		for (i = 0; i < items; i++) begin
			k = $urandom_range(0, 99);
			if (k < 70) begin
				if ($urandom_range(0, 9) == 0)
					queue_cmd(MODE_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
				else
					queue_cmd(MODE_ADD, $urandom_range(0, lim-1), $urandom_range(0, lim-1));
			end else if (k < 90) queue_cmd(MODE_QUERY, $urandom, $urandom);
			else if (k < 96) queue_cmd(MODE_CLEAR, $urandom, $urandom);
			else queue_cmd(MODE_UNUSED, $urandom, $urandom);
		end
	endtask

	initial begin
		foreach (adj[i]) adj[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: tree, then cycle, self-loop, bad endpoints, unused mode
		queue_cmd(MODE_QUERY, 0, 0);
		queue_cmd(MODE_ADD, 0, 1);
		queue_cmd(MODE_ADD, 1, 2);
		queue_cmd(MODE_ADD, 1, 0);
		queue_cmd(MODE_QUERY, 0, 0);
		queue_cmd(MODE_ADD, 2, 0);
		queue_cmd(MODE_QUERY, 63, 63);
		queue_cmd(MODE_CLEAR, 0, 0);
		queue_cmd(MODE_ADD, 63, 63);
		queue_cmd(MODE_QUERY, 0, 0);
		queue_cmd(MODE_CLEAR, 0, 0);
		queue_cmd(MODE_UNUSED, 63, 63);
		queue_cmd(MODE_ADD, 62, 63);
		queue_cmd(MODE_QUERY, 0, 0);
		drain();
		write_count(3);
		queue_cmd(MODE_ADD, 3, 0);
		queue_cmd(MODE_ADD, 0, 3);
		queue_cmd(MODE_QUERY, 0, 0);
		queue_cmd(MODE_ADD, 2, 2);
		queue_cmd(MODE_QUERY, 0, 0);
		drain();
		write_count(0);
		queue_cmd(MODE_ADD, 0, 0);
		queue_cmd(MODE_QUERY, 0, 0);
		drain();
		write_count(127);
		queue_cmd(MODE_QUERY, 0, 0);
		queue_cmd(MODE_CLEAR, 0, 0);
		drain();
		write_count(1);
		random_phase(60, 1);
		drain();
		write_count(8);
		random_phase(250, 8);
		drain();
		write_count(64);
		queue_cmd(MODE_CLEAR, 0, 0);
		random_phase(200, 64);
		drain();
		write_count(20);
		random_phase(200, 20);
		drain();
		write_count(100);
		idle_en = 0;
		gap_left = 0;
		random_phase(150, 64);
		drain();
		if (mismatches == 0) $display("undirected_cycle_detect_tb passed");
		else $display("undirected_cycle_detect_tb failed");
		$finish;
	end

endmodule
